FILE: rtl/core/cdt_pkg.sv
package cdt_pkg;

  // width of the limit register and of the body byte counter
  localparam int unsigned LIMIT_W = 32;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 32'd1048576;

  // apb register map
  localparam int unsigned ADDR_W = 3;
  localparam logic REG_LIMIT = 1'b0;

  // entries in the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  // ascii codes the parser cares about
  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_LF = 8'h0a;

  typedef enum logic [2:0] {
    PH_SIZE  = 3'd0,
    PH_LF    = 3'd1,
    PH_BODY  = 3'd2,
    PH_TRAIL = 3'd3,
    PH_DONE  = 3'd4,
    PH_FMT   = 3'd5,
    PH_LONG  = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    ST_DATA = 2'd0,
    ST_DONE = 2'd1,
    ST_FMT  = 2'd2,
    ST_LONG = 2'd3
  } status_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] payload_byte;
    logic       chunk_end;
  } result_t;

  // {is_hex, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7a) ||
           (c >= 8'h41 && c <= 8'h5a);
  endfunction

endpackage

FILE: rtl/core/cdt_front.sv
module cdt_front #(
  parameter int unsigned SIZE_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_fire,
  input  logic [7:0]                   in_data_byte,
  input  logic [cdt_pkg::LIMIT_W-1:0]  limit,
  output logic                         push,
  output cdt_pkg::result_t             push_data
);

  localparam int unsigned CMP_W = (SIZE_WIDTH > cdt_pkg::LIMIT_W) ? SIZE_WIDTH
                                                                  : cdt_pkg::LIMIT_W;

  cdt_pkg::phase_t              phase_r, phase_nxt;
  logic [SIZE_WIDTH-1:0]        size_value_r, size_value_nxt;
  logic                         hex_ended_r, hex_ended_nxt;
  logic [cdt_pkg::LIMIT_W-1:0]  bytes_left_r, bytes_left_nxt;
  logic                         trailer_count_r, trailer_count_nxt;
  logic [4:0]                   digit;
  logic                         last;

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= cdt_pkg::PH_SIZE;
      size_value_r    <= '0;
      hex_ended_r     <= 1'b0;
      bytes_left_r    <= '0;
      trailer_count_r <= 1'b0;
    end else begin
      phase_r         <= phase_nxt;
      size_value_r    <= size_value_nxt;
      hex_ended_r     <= hex_ended_nxt;
      bytes_left_r    <= bytes_left_nxt;
      trailer_count_r <= trailer_count_nxt;
    end
  end

  assign digit = cdt_pkg::hex_digit(in_data_byte);
  assign last  = (bytes_left_r <= cdt_pkg::LIMIT_W'(1));

  // classify one byte and form its result
  always_comb begin
    phase_nxt         = phase_r;
    size_value_nxt    = size_value_r;
    hex_ended_nxt     = hex_ended_r;
    bytes_left_nxt    = bytes_left_r;
    trailer_count_nxt = trailer_count_r;
    push              = 1'b0;
    push_data         = '{status: cdt_pkg::ST_DATA, payload_byte: 8'd0, chunk_end: 1'b0};
    if (in_fire) begin
      case (phase_r)
        cdt_pkg::PH_SIZE: begin
          if (cdt_pkg::is_alnum(in_data_byte)) begin
            if (!digit[4]) begin
              hex_ended_nxt = 1'b1;
            end else if (!hex_ended_r) begin
              // saturate once the top nibble is nonzero, so that another digit would shift it out
              if (size_value_r[SIZE_WIDTH-1 -: 4] != 4'd0) begin
                size_value_nxt = '1;
              end else begin
                size_value_nxt = {size_value_r[SIZE_WIDTH-5:0], digit[3:0]};
              end
            end
          end else if (in_data_byte == cdt_pkg::CH_CR) begin
            phase_nxt = cdt_pkg::PH_LF;
          end else begin
            phase_nxt        = cdt_pkg::PH_FMT;
            push             = 1'b1;
            push_data.status = cdt_pkg::ST_FMT;
          end
        end
        cdt_pkg::PH_LF: begin
          if (in_data_byte != cdt_pkg::CH_LF) begin
            phase_nxt        = cdt_pkg::PH_FMT;
            push             = 1'b1;
            push_data.status = cdt_pkg::ST_FMT;
          end else begin
            size_value_nxt = '0;
            hex_ended_nxt  = 1'b0;
            if (size_value_r == '0) begin
              phase_nxt        = cdt_pkg::PH_DONE;
              push             = 1'b1;
              push_data.status = cdt_pkg::ST_DONE;
            end else if (CMP_W'(size_value_r) > CMP_W'(limit)) begin
              phase_nxt        = cdt_pkg::PH_LONG;
              push             = 1'b1;
              push_data.status = cdt_pkg::ST_LONG;
            end else begin
              bytes_left_nxt = cdt_pkg::LIMIT_W'(size_value_r);
              phase_nxt      = cdt_pkg::PH_BODY;
            end
          end
        end
        cdt_pkg::PH_BODY: begin
          push                   = 1'b1;
          push_data.payload_byte = in_data_byte;
          push_data.chunk_end    = last;
          if (last) begin
            bytes_left_nxt    = '0;
            trailer_count_nxt = 1'b0;
            phase_nxt         = cdt_pkg::PH_TRAIL;
          end else begin
            bytes_left_nxt = bytes_left_r - cdt_pkg::LIMIT_W'(1);
          end
        end
        cdt_pkg::PH_TRAIL: begin
          // crlf after the body, not checked
          if (!trailer_count_r) begin
            trailer_count_nxt = 1'b1;
          end else begin
            trailer_count_nxt = 1'b0;
            phase_nxt         = cdt_pkg::PH_SIZE;
          end
        end
        cdt_pkg::PH_DONE: begin
          push = 1'b0;
        end
        cdt_pkg::PH_LONG: begin
          push             = 1'b1;
          push_data.status = cdt_pkg::ST_LONG;
        end
        default: begin
          phase_nxt        = cdt_pkg::PH_FMT;
          push             = 1'b1;
          push_data.status = cdt_pkg::ST_FMT;
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/cdt_fifo.sv
module cdt_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  cdt_pkg::result_t  push_data,
  input  logic              pop,
  output logic              empty,
  output logic              full,
  output cdt_pkg::result_t  head
);

  cdt_pkg::result_t                 entry_r [cdt_pkg::QUEUE_DEPTH];
  logic [cdt_pkg::QPTR_W-1:0]       wr_ptr_r, rd_ptr_r;
  logic [cdt_pkg::QCNT_W-1:0]       count_r, count_nxt;
  logic                             do_push, do_pop;

  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign empty   = (count_r == '0);
  assign full    = (count_r == cdt_pkg::QCNT_W'(cdt_pkg::QUEUE_DEPTH));
  assign head    = entry_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + cdt_pkg::QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - cdt_pkg::QCNT_W'(1);
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + cdt_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + cdt_pkg::QPTR_W'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/core/cdt_back.sv
module cdt_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  cdt_pkg::result_t  q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_status,
  output logic [7:0]        out_payload_byte,
  output logic              out_chunk_end
);

  logic              out_valid_r;
  cdt_pkg::result_t  out_data_r;

  // refill the output register when it is empty or being taken
  assign q_pop = !q_empty && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data_r <= q_head;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_data_r.status;
  assign out_payload_byte = out_data_r.payload_byte;
  assign out_chunk_end    = out_data_r.chunk_end;

endmodule

FILE: rtl/core/chunked_transfer_decoder_top.sv
// chunked transfer decoder
// input transaction: one raw byte of a chunked body on in_data_byte, taken
//   when in_valid is high and in_stall is low; one byte per cycle sustained.
// output transaction: status, payload_byte and chunk_end, taken when
//   out_valid is high and out_stall is low. size-line and crlf bytes give no
//   output; body bytes give status 0 with chunk_end on the last byte; the lf
//   of a zero size gives status 1 (complete), after which nothing comes out;
//   format errors (2) and oversize chunks (3) repeat for every later byte.
// path: each byte is parsed combinationally in the cycle it is taken, its
//   result goes into a two-entry queue at that edge and the back end moves
//   it into the output register once that register is empty or being taken.
// throughput: one byte per cycle; the parser state update is the loop that
//   sets it. when the receiver stalls, the queue fills and in_stall rises.
// reset (rst_n low, synchronous): parser back to the size line, queue and
//   output register empty, chunk_size_limit back to 1048576.
// the apb port at byte address 0 holds chunk_size_limit; write it only
//   while the block is idle.
module chunked_transfer_decoder_top #(
  parameter int unsigned SIZE_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   in_data_byte,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   out_status,
  output logic [7:0]                   out_payload_byte,
  output logic                         out_chunk_end,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cdt_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  logic [cdt_pkg::LIMIT_W-1:0]  limit_r;
  logic                         in_fire;
  logic                         push;
  cdt_pkg::result_t             push_data;
  logic                         q_empty;
  logic                         q_full;
  logic                         q_pop;
  cdt_pkg::result_t             q_head;

  // configuration register
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= cdt_pkg::LIMIT_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == cdt_pkg::REG_LIMIT)) begin
      limit_r <= pwdata;
    end
  end
  assign prdata = (paddr[2] == cdt_pkg::REG_LIMIT) ? limit_r : 32'd0;

  // input handshake
  assign in_stall = q_full;
  assign in_fire  = in_valid && !q_full;

  cdt_front #(
    .SIZE_WIDTH (SIZE_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_fire      (in_fire),
    .in_data_byte (in_data_byte),
    .limit        (limit_r),
    .push         (push),
    .push_data    (push_data)
  );

  cdt_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (q_pop),
    .empty     (q_empty),
    .full      (q_full),
    .head      (q_head)
  );

  cdt_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_payload_byte (out_payload_byte),
    .out_chunk_end    (out_chunk_end)
  );

endmodule

FILE: rtl/core/cdt_checker.sv
module cdt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_status,
  input logic [7:0] out_payload_byte,
  input logic       out_chunk_end
);

  logic out_fire;
  assign out_fire = out_valid && !out_stall;

  // chunk end only marks payload bytes
  a_end_is_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_chunk_end |-> out_status == cdt_pkg::ST_DATA)
    else $error("chunk_end on a non-payload transaction");

  // status transactions carry no byte
  a_status_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != cdt_pkg::ST_DATA |-> out_payload_byte == 8'd0)
    else $error("payload byte on a status transaction");

  // nothing follows stream completion
  a_done_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && out_status == cdt_pkg::ST_DONE |=> !out_valid)
    else $error("transaction after stream complete");

  // format error is sticky
  a_fmt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && out_status == cdt_pkg::ST_FMT |=>
      !out_valid || out_status == cdt_pkg::ST_FMT)
    else $error("format error not sticky");

  // too-long error is sticky
  a_long_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && out_status == cdt_pkg::ST_LONG |=>
      !out_valid || out_status == cdt_pkg::ST_LONG)
    else $error("too-long error not sticky");

endmodule

bind chunked_transfer_decoder_top cdt_checker u_cdt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_status       (out_status),
  .out_payload_byte (out_payload_byte),
  .out_chunk_end    (out_chunk_end)
);

FILE: bench/chunked_transfer_decoder_checker.sv
`timescale 1ns / 100ps

module chunked_transfer_decoder_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [7:0]                 in_data_byte,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [1:0]                 out_status,
  input  logic [7:0]                 out_payload_byte,
  input  logic                       out_chunk_end,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cdt_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  input  logic [31:0]                prdata,
  input  logic                       pready,
  output int unsigned                pending,
  output int unsigned                fail_count
);

  localparam logic [cdt_pkg::ADDR_W-1:0] LIMIT_ADDR =
    cdt_pkg::ADDR_W'(4 * cdt_pkg::REG_LIMIT);

  // mirror of the parser state
  cdt_pkg::phase_t             parse_phase;
  logic [cdt_pkg::LIMIT_W-1:0] size_acc;
  logic [cdt_pkg::LIMIT_W-1:0] body_left;
  logic [cdt_pkg::LIMIT_W-1:0] size_limit;
  bit                          past_digits;
  bit                          trail_seen;

  // decoded results still waiting for their output transaction
  cdt_pkg::result_t decoded_results[$];

  cdt_pkg::result_t want;
  cdt_pkg::result_t decoded;
  bit               has_result;

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t: %s", $time, msg);
    end
  endtask

  // advance the parser by one stream byte, returns 1 when it yields a result
  function automatic bit parse_stream_byte(input logic [7:0] c,
                                           output cdt_pkg::result_t r);
    logic [3:0]                  nib;
    logic [cdt_pkg::LIMIT_W-1:0] line_size;
    bit                          is_digit;
    bit                          is_hex_letter;
    bit                          is_letter;
    bit                          emits;
    emits = 1'b0;
    r = '0;
    is_digit = (c >= "0" && c <= "9");
    is_hex_letter = (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    is_letter = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    nib = is_digit ? c[3:0] : c[3:0] + 4'd9;
    case (parse_phase)
      cdt_pkg::PH_SIZE: begin
        if (is_digit || is_letter) begin
          if (!(is_digit || is_hex_letter)) begin
            past_digits = 1'b1;
          end else if (!past_digits) begin
            // saturate instead of wrapping
            if (size_acc[cdt_pkg::LIMIT_W-1 -: 4] != 4'h0) begin
              size_acc = '1;
            end else begin
              size_acc = {size_acc[cdt_pkg::LIMIT_W-5:0], nib};
            end
          end
        end else if (c == cdt_pkg::CH_CR) begin
          parse_phase = cdt_pkg::PH_LF;
        end else begin
          parse_phase = cdt_pkg::PH_FMT;
          r.status = cdt_pkg::ST_FMT;
          emits = 1'b1;
        end
      end
      cdt_pkg::PH_LF: begin
        if (c != cdt_pkg::CH_LF) begin
          parse_phase = cdt_pkg::PH_FMT;
          r.status = cdt_pkg::ST_FMT;
          emits = 1'b1;
        end else begin
          line_size = size_acc;
          size_acc = '0;
          past_digits = 1'b0;
          if (line_size == 0) begin
            parse_phase = cdt_pkg::PH_DONE;
            r.status = cdt_pkg::ST_DONE;
            emits = 1'b1;
          end else if (line_size > size_limit) begin
            parse_phase = cdt_pkg::PH_LONG;
            r.status = cdt_pkg::ST_LONG;
            emits = 1'b1;
          end else begin
            body_left = line_size;
            parse_phase = cdt_pkg::PH_BODY;
          end
        end
      end
      cdt_pkg::PH_BODY: begin
        r.status = cdt_pkg::ST_DATA;
        r.payload_byte = c;
        r.chunk_end = (body_left <= 1);
        emits = 1'b1;
        if (body_left <= 1) begin
          body_left = '0;
          trail_seen = 1'b0;
          parse_phase = cdt_pkg::PH_TRAIL;
        end else begin
          body_left = body_left - 1;
        end
      end
      // two bytes after a body, not checked
      cdt_pkg::PH_TRAIL: begin
        if (!trail_seen) begin
          trail_seen = 1'b1;
        end else begin
          trail_seen = 1'b0;
          parse_phase = cdt_pkg::PH_SIZE;
        end
      end
      cdt_pkg::PH_DONE: begin
      end
      cdt_pkg::PH_LONG: begin
        r.status = cdt_pkg::ST_LONG;
        emits = 1'b1;
      end
      default: begin
        parse_phase = cdt_pkg::PH_FMT;
        r.status = cdt_pkg::ST_FMT;
        emits = 1'b1;
      end
    endcase
    return emits;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      parse_phase = cdt_pkg::PH_SIZE;
      size_acc = '0;
      body_left = '0;
      past_digits = 1'b0;
      trail_seen = 1'b0;
      size_limit = cdt_pkg::LIMIT_RESET;
      decoded_results.delete();
      fail_count = 0;
      pending <= 0;
    end else begin
      // register access
      if (psel && penable && pready && paddr == LIMIT_ADDR) begin
        if (pwrite) begin
          size_limit = pwdata;
        end else if (prdata !== size_limit) begin
          note_failure($sformatf("limit readback exp %08h got %08h", size_limit, prdata));
        end
      end

      // output transaction against the oldest decoded result
      if (out_valid && !out_stall) begin
        if (decoded_results.size() == 0) begin
          note_failure($sformatf("unexpected result status %0d byte %02h end %0b",
                                 out_status, out_payload_byte, out_chunk_end));
        end else begin
          want = decoded_results.pop_front();
          if (out_status !== want.status || out_payload_byte !== want.payload_byte ||
              out_chunk_end !== want.chunk_end) begin
            note_failure($sformatf(
              "mismatch status exp %0d got %0d, byte exp %02h got %02h, end exp %0b got %0b",
              want.status, out_status, want.payload_byte, out_payload_byte,
              want.chunk_end, out_chunk_end));
          end
        end
      end

      // input transaction
      if (in_valid && !in_stall) begin
        has_result = parse_stream_byte(in_data_byte, decoded);
        if (has_result) begin
          decoded_results.push_back(decoded);
        end
      end
      pending <= decoded_results.size();
    end
  end

endmodule

FILE: bench/tb_chunked_transfer_decoder_top.sv
`timescale 1ns / 100ps

module tb_chunked_transfer_decoder_top;

  localparam logic [cdt_pkg::ADDR_W-1:0] LIMIT_ADDR =
    cdt_pkg::ADDR_W'(4 * cdt_pkg::REG_LIMIT);
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned PHASES = 8;
  localparam int unsigned PHASE_BYTES = 240;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [7:0]                 in_data_byte = 8'h00;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [1:0]                 out_status;
  logic [7:0]                 out_payload_byte;
  logic                       out_chunk_end;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [cdt_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0]                pwdata = 32'h0;
  logic [31:0]                prdata;
  logic                       pready;

  int unsigned pending;
  int unsigned fail_count;
  int unsigned bytes_sent = 0;
  int unsigned quiet_cycles = 0;
  int unsigned stall_left = 0;
  int unsigned stall_roll;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;

  string alnum_chars = "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
  string hex_chars = "0123456789abcdefABCDEF";

  always #1 clk = ~clk;

  chunked_transfer_decoder_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_payload_byte (out_payload_byte),
    .out_chunk_end    (out_chunk_end),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  chunked_transfer_decoder_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_payload_byte (out_payload_byte),
    .out_chunk_end    (out_chunk_end),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .pending          (pending),
    .fail_count       (fail_count)
  );

  // receiver backpressure: mostly short stalls, a few long ones
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (rx_calm) begin
      out_stall <= 1'b0;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 60) begin
        out_stall <= 1'b0;
      end else if (stall_roll < 92) begin
        out_stall <= 1'b1;
        stall_left <= $urandom_range(0, 2);
      end else begin
        out_stall <= 1'b1;
        stall_left <= $urandom_range(8, 30);
      end
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one input transaction, after a random gap that may be zero
  task automatic send_byte(input logic [7:0] b);
    int unsigned roll;
    int unsigned gap;
    roll = $urandom_range(0, 99);
    if (tx_calm || roll < 55) begin
      gap = 0;
    end else if (roll < 90) begin
      gap = $urandom_range(1, 3);
    end else begin
      gap = $urandom_range(8, 30);
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  // stop sending and wait until every result is out and the pipe is empty
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic apb_access(input bit wr, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= LIMIT_ADDR;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // write the limit and read it back, block must be drained
  task automatic program_limit(input logic [31:0] value);
    apb_access(1'b1, value);
    apb_access(1'b0, 32'h0);
  endtask

  task automatic send_size_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) begin
      send_byte(s[i]);
    end
    send_byte(cdt_pkg::CH_CR);
    send_byte(cdt_pkg::CH_LF);
  endtask

  // size line in hex with optional leading zeros, random letter case and an optional extension
  task automatic send_size_line(input logic [31:0] len);
    int         i;
    int         digits;
    logic [3:0] nib;
    bit         upper;
    digits = 8;
    while (digits > 1 && len[4*digits-1 -: 4] == 4'h0) digits--;
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) send_byte("0");
    end
    upper = 1'($urandom_range(0, 1));
    for (i = digits; i > 0; i--) begin
      nib = len[4*i-1 -: 4];
      send_byte(nib < 10 ? 8'h30 + nib : (upper ? 8'h37 : 8'h57) + nib);
    end
    if ($urandom_range(0, 3) == 0) begin
      send_byte($urandom_range(0, 1) ? 8'($urandom_range(8'h67, 8'h7a)) :
                                       8'($urandom_range(8'h47, 8'h5a)));
      repeat ($urandom_range(0, 3)) send_byte(alnum_chars[$urandom_range(0, alnum_chars.len() - 1)]);
    end
    send_byte(cdt_pkg::CH_CR);
    send_byte(cdt_pkg::CH_LF);
  endtask

  // random body bytes and the two bytes that follow
  task automatic send_body(input int unsigned len);
    repeat (len) send_byte(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 1)) begin
      send_byte(cdt_pkg::CH_CR);
      send_byte(cdt_pkg::CH_LF);
    end else begin
      repeat (2) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int unsigned p;
    int unsigned phase_start;
    int unsigned cap;
    int unsigned len;
    int unsigned roll;
    logic [31:0] lim;
    logic [7:0]  bad;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: single byte chunk, digits after a letter, edge byte values
    send_size_text("1");
    send_byte(8'h00);
    send_byte(cdt_pkg::CH_CR);
    send_byte(cdt_pkg::CH_LF);
    send_size_text("2zz9");
    send_byte(8'hFF);
    send_byte(cdt_pkg::CH_LF);
    send_byte(8'h00);
    send_byte(8'hFF);
    drain();
    apb_access(1'b0, 32'h0);

    // random chunks under several limits
    for (p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: lim = 32'hFFFF_FFFF;
        1: lim = cdt_pkg::LIMIT_RESET;
        2: lim = $urandom_range(1, 16);
        3: lim = $urandom_range(64, 32'h7FFF_FFFF);
        default: begin
          case ($urandom_range(0, 2))
            0: lim = 32'hFFFF_FFFF;
            1: lim = $urandom_range(1, 16);
            default: lim = $urandom_range(17, 1 << 20);
          endcase
        end
      endcase
      program_limit(lim);
      tx_calm = (p % 4 == 3) || ($urandom_range(0, 3) == 0);
      rx_calm = (p % 4 == 3) || ($urandom_range(0, 3) == 0);
      cap = (lim < 48) ? lim : 48;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        roll = $urandom_range(0, 9);
        if (roll < 7) begin
          len = $urandom_range(1, (cap < 12) ? cap : 12);
        end else if (roll < 9) begin
          len = $urandom_range(1, cap);
        end else begin
          len = cap;
        end
        send_size_line(len);
        send_body(len);
        // occasionally let everything drain mid-stream
        if ($urandom_range(0, 19) == 0) begin
          drain();
        end
      end
    end

    // one terminal case per run, then noise to check the sticky behavior
    drain();
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    program_limit(32'h0);
    case ($urandom_range(0, 4))
      0: send_size_line(32'h0);
      1: begin
        if ($urandom_range(0, 1)) begin
          send_size_text("");
        end else begin
          send_size_text("0x1f");
        end
      end
      2: begin
        repeat ($urandom_range(0, 3)) send_byte(alnum_chars[$urandom_range(0, alnum_chars.len() - 1)]);
        do begin
          bad = 8'($urandom_range(0, 255));
        end while ((bad >= "0" && bad <= "9") || (bad >= "a" && bad <= "z") ||
                   (bad >= "A" && bad <= "Z") || bad == cdt_pkg::CH_CR);
        send_byte(bad);
      end
      3: begin
        send_byte(hex_chars[$urandom_range(0, hex_chars.len() - 1)]);
        send_byte(cdt_pkg::CH_CR);
        do begin
          bad = 8'($urandom_range(0, 255));
        end while (bad == cdt_pkg::CH_LF);
        send_byte(bad);
      end
      default: begin
        case ($urandom_range(0, 2))
          0: send_size_line($urandom_range(1, 40));
          1: begin
            lim = $urandom_range(1, 1 << 20);
            program_limit(lim);
            send_size_line(lim + 1);
          end
          default: begin
            // size overflows and saturates above the limit
            lim = $urandom_range(0, 32'hFFFF_FFFE);
            program_limit(lim);
            send_byte("1");
            repeat ($urandom_range(8, 12)) send_byte(hex_chars[$urandom_range(0, hex_chars.len() - 1)]);
            send_byte(cdt_pkg::CH_CR);
            send_byte(cdt_pkg::CH_LF);
          end
        endcase
      end
    endcase
    repeat (30) send_byte(8'($urandom_range(0, 255)));
    drain();

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
